// ----- design/tcct_pkg.sv -----
// Shared types and constants for the text console cursor tracker.
package tcct_pkg;

  localparam int unsigned MaxResults = 5;
  localparam int unsigned CntW       = 3;

  localparam logic [7:0] ResetCols = 8'd80;
  localparam logic [6:0] ResetRows = 7'd24;

  // configuration register indexes
  localparam logic CfgNumCols = 1'b0;
  localparam logic CfgNumRows = 1'b1;

  // character codes after masking to 7 bits
  localparam logic [6:0] CharMask      = 7'h7F;
  localparam logic [6:0] CharBackspace = 7'h08;
  localparam logic [6:0] CharNewline   = 7'h0A;
  localparam logic [6:0] CharReturn    = 7'h0D;
  localparam logic [6:0] CharSpace     = 7'h20;
  localparam logic [6:0] CharDel       = 7'h7F;

  typedef enum logic [2:0] {
    CMD_GLYPH  = 3'd0,
    CMD_MOVE   = 3'd1,
    CMD_DRAW   = 3'd2,
    CMD_SCROLL = 3'd3,
    CMD_CLEAR  = 3'd4
  } tcct_cmd_e;

  typedef struct packed {
    tcct_cmd_e  command;
    logic [6:0] row;
    logic [7:0] col;
    logic [6:0] glyph;
    logic [7:0] clear_width;
  } tcct_entry_t;

endpackage

// ----- design/tcct_decode.sv -----
// Character decode: display commands and next cursor for one character.
module tcct_decode (
  input  logic [7:0]                                char_code_i,
  input  logic [7:0]                                num_cols_i,
  input  logic [6:0]                                num_rows_i,
  input  logic [7:0]                                cur_col_i,
  input  logic [6:0]                                cur_row_i,
  output tcct_pkg::tcct_entry_t [tcct_pkg::MaxResults-1:0] entries_o,
  output logic [tcct_pkg::CntW-1:0]                 count_o,
  output logic [7:0]                                next_col_o,
  output logic [6:0]                                next_row_o
);
  import tcct_pkg::*;

  function automatic tcct_entry_t mk(tcct_cmd_e cmd, logic [6:0] row, logic [7:0] col,
                                     logic [6:0] glyph, logic [7:0] width);
    tcct_entry_t e;
    e.command     = cmd;
    e.row         = row;
    e.col         = col;
    e.glyph       = glyph;
    e.clear_width = width;
    return e;
  endfunction

  logic [6:0] ch;
  logic [7:0] cols_eff;
  logic [6:0] rows_eff;
  logic [6:0] last_row;
  logic [7:0] row_inc;
  logic [8:0] col_inc;
  logic       at_bottom;
  logic       wrap;
  logic       printable;

  assign ch        = char_code_i[6:0] & CharMask;
  assign cols_eff  = (num_cols_i == 8'd0) ? 8'd1 : num_cols_i;
  assign rows_eff  = (num_rows_i == 7'd0) ? 7'd1 : num_rows_i;
  assign last_row  = rows_eff - 7'd1;
  assign row_inc   = {1'b0, cur_row_i} + 8'd1;
  assign col_inc   = {1'b0, cur_col_i} + 9'd1;
  // compares are >= so a cursor left outside a shrunken screen still wraps/scrolls
  assign at_bottom = row_inc >= {1'b0, rows_eff};
  assign wrap      = col_inc >= {1'b0, cols_eff};
  assign printable = (ch >= CharSpace) && (ch != CharDel);

  always_comb begin
    entries_o  = '0;
    count_o    = '0;
    next_col_o = cur_col_i;
    next_row_o = cur_row_i;
    if (ch == CharNewline) begin
      if (at_bottom) begin
        entries_o[0] = mk(CMD_SCROLL, 7'd0, 8'd0, 7'd0, 8'd0);
        entries_o[1] = mk(CMD_CLEAR, last_row, 8'd0, 7'd0, cols_eff);
        entries_o[2] = mk(CMD_DRAW, last_row, cur_col_i, 7'd0, 8'd0);
        count_o      = CntW'(3);
        next_row_o   = last_row;
      end else begin
        entries_o[0] = mk(CMD_MOVE, row_inc[6:0], cur_col_i, 7'd0, 8'd0);
        count_o      = CntW'(1);
        next_row_o   = row_inc[6:0];
      end
    end else if (ch == CharReturn) begin
      entries_o[0] = mk(CMD_MOVE, cur_row_i, 8'd0, 7'd0, 8'd0);
      count_o      = CntW'(1);
      next_col_o   = 8'd0;
    end else if (ch == CharBackspace) begin
      if (cur_col_i != 8'd0) begin
        entries_o[0] = mk(CMD_MOVE, cur_row_i, cur_col_i - 8'd1, 7'd0, 8'd0);
        count_o      = CntW'(1);
        next_col_o   = cur_col_i - 8'd1;
      end
    end else if (printable) begin
      entries_o[0] = mk(CMD_GLYPH, cur_row_i, cur_col_i, ch, 8'd0);
      entries_o[1] = mk(CMD_DRAW, cur_row_i, cur_col_i, 7'd0, 8'd0);
      if (wrap) begin
        next_col_o = 8'd0;
        if (at_bottom) begin
          entries_o[2] = mk(CMD_SCROLL, 7'd0, 8'd0, 7'd0, 8'd0);
          entries_o[3] = mk(CMD_CLEAR, last_row, 8'd0, 7'd0, cols_eff);
          entries_o[4] = mk(CMD_DRAW, last_row, 8'd0, 7'd0, 8'd0);
          count_o      = CntW'(5);
          next_row_o   = last_row;
        end else begin
          entries_o[2] = mk(CMD_MOVE, row_inc[6:0], 8'd0, 7'd0, 8'd0);
          count_o      = CntW'(3);
          next_row_o   = row_inc[6:0];
        end
      end else begin
        entries_o[2] = mk(CMD_MOVE, cur_row_i, col_inc[7:0], 7'd0, 8'd0);
        count_o      = CntW'(3);
        next_col_o   = col_inc[7:0];
      end
    end
  end

endmodule

// ----- design/text_console_cursor_tracker.sv -----
// Top level of the text console cursor tracker.
//
// Input channel (in_valid_i/in_ready_o, char_code_i): one character per request.
// Output channel (out_valid_o/out_ready_i): one display command per request,
// fields command/row/col/glyph/clear_width, with last_o on the final command
// of a character. A character yields 0 to 5 commands.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 = num_cols, 1 = num_rows); write only while the block is idle.
// A taken character's commands are loaded into the command queue, then move
// one at a time into the output register. Throughput: one command per cycle
// while the receiver does not stall, so characters follow back to back.
// The next character is taken in the cycle its predecessor's final command
// moves into the output register.
// Reset: cursor at row 0, column 0; 80 columns, 24 rows; queue and output empty.
// When the receiver stalls, the output register holds its command and the
// queue, then the input, stop in turn.
module text_console_cursor_tracker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] command_o,
  output logic [6:0] row_o,
  output logic [7:0] col_o,
  output logic [6:0] glyph_o,
  output logic [7:0] clear_width_o,
  output logic       last_o
);
  import tcct_pkg::*;

  logic [7:0] num_cols_q;
  logic [6:0] num_rows_q;
  logic [7:0] cursor_col_q, cursor_col_d;
  logic [6:0] cursor_row_q, cursor_row_d;

  tcct_entry_t [MaxResults-1:0] list_q, list_d, dec_entries;
  logic [CntW-1:0] rem_q, rem_d, dec_count;

  logic        out_valid_q, out_valid_d;
  tcct_entry_t out_entry_q;
  logic        out_last_q;

  logic pop, accept;

  tcct_decode u_decode (
    .char_code_i (char_code_i),
    .num_cols_i  (num_cols_q),
    .num_rows_i  (num_rows_q),
    .cur_col_i   (cursor_col_q),
    .cur_row_i   (cursor_row_q),
    .entries_o   (dec_entries),
    .count_o     (dec_count),
    .next_col_o  (cursor_col_d),
    .next_row_o  (cursor_row_d)
  );

  assign pop        = (rem_q != '0) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (rem_q == '0) || ((rem_q == CntW'(1)) && pop);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    list_d = list_q;
    rem_d  = rem_q;
    if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        list_d[i] = list_q[i+1];
      end
      rem_d = rem_q - CntW'(1);
    end
    if (accept) begin
      list_d = dec_entries;
      rem_d  = dec_count;
    end
  end

  assign out_valid_d = pop || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q   <= ResetCols;
      num_rows_q   <= ResetRows;
      cursor_col_q <= '0;
      cursor_row_q <= '0;
      rem_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgNumCols: num_cols_q <= cfg_wdata_i;
          CfgNumRows: num_rows_q <= cfg_wdata_i[6:0];
          default:    num_cols_q <= num_cols_q;
        endcase
      end
      if (accept) begin
        cursor_col_q <= cursor_col_d;
        cursor_row_q <= cursor_row_d;
      end
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    list_q <= list_d;
    if (pop) begin
      out_entry_q <= list_q[0];
      out_last_q  <= (rem_q == CntW'(1));
    end
  end

  assign out_valid_o   = out_valid_q;
  assign command_o     = out_entry_q.command;
  assign row_o         = out_entry_q.row;
  assign col_o         = out_entry_q.col;
  assign glyph_o       = out_entry_q.glyph;
  assign clear_width_o = out_entry_q.clear_width;
  assign last_o        = out_last_q;

endmodule

// ----- design/tcct_checker.sv -----
// Port-level assertions for the text console cursor tracker, bound to the top level.
module tcct_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] command_o,
  input logic [7:0] clear_width_o,
  input logic       last_o
);
  import tcct_pkg::*;

  // a stalled command stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(command_o) && $stable(last_o))
    else $error("output command changed while stalled");

  // scroll is always followed at once by the bottom line clear
  a_scroll_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && command_o == CMD_SCROLL
      |=> out_valid_o && command_o == CMD_CLEAR)
    else $error("scroll not followed by clear");

  a_glyph_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (command_o == CMD_GLYPH || command_o == CMD_SCROLL) |-> !last_o)
    else $error("glyph or scroll marked as last command");

  a_clear_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && command_o == CMD_CLEAR |-> clear_width_o != 8'd0 && !last_o)
    else $error("clear command with zero width or marked last");

endmodule

bind text_console_cursor_tracker tcct_checker u_tcct_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .command_o     (command_o),
  .clear_width_o (clear_width_o),
  .last_o        (last_o)
);

// ----- tb/tb.sv -----
// Testbench for the text console cursor tracker: directed and random character streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcct_pkg::*;

  localparam int StallLimit = 2000;  // cycles with no request accepted
  localparam int IdleCycles = 10;    // settle time before a register write
  localparam int IdlePct    = 33;

  typedef struct packed {
    tcct_cmd_e  command;
    logic [6:0] row;
    logic [7:0] col;
    logic [6:0] glyph;
    logic [7:0] clear_width;
    logic       last;
  } disp_cmd_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_idx_i   = CfgNumCols;
  logic [7:0] cfg_wdata_i = 8'd0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_code_i = 8'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] command_o;
  logic [6:0] row_o;
  logic [7:0] col_o;
  logic [6:0] glyph_o;
  logic [7:0] clear_width_o;
  logic       last_o;

  text_console_cursor_tracker DUT (.*);

  // screen model
  logic [7:0] cols_q  = ResetCols;
  logic [6:0] rows_q  = ResetRows;
  logic [7:0] cur_col = 8'd0;
  logic [6:0] cur_row = 7'd0;

  disp_cmd_t step_cmds[$];
  disp_cmd_t pending_cmds[$];

  int  mismatch_cnt = 0;
  int  quiet_cycles = 0;
  bit  in_idle_en   = 1'b1;
  bit  out_idle_en  = 1'b1;

  // handshake and payload as seen just before the next rising edge
  bit         in_fire  = 1'b0;
  bit         out_fire = 1'b0;
  logic [7:0] seen_char;
  logic [2:0] seen_cmd;
  logic [6:0] seen_row;
  logic [7:0] seen_col;
  logic [6:0] seen_glyph;
  logic [7:0] seen_width;
  logic       seen_last;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    in_fire    = rst_ni && in_valid_i && in_ready_o;
    out_fire   = rst_ni && out_valid_o && out_ready_i;
    seen_char  = char_code_i;
    seen_cmd   = command_o;
    seen_row   = row_o;
    seen_col   = col_o;
    seen_glyph = glyph_o;
    seen_width = clear_width_o;
    seen_last  = last_o;
  end

  always @(posedge clk_i) begin
    out_ready_i <= out_idle_en ? ($urandom_range(99) >= IdlePct) : 1'b1;
  end

  function automatic void add_cmd(input tcct_cmd_e cmd, input logic [6:0] r,
                                  input logic [7:0] c, input logic [6:0] g,
                                  input logic [7:0] w);
    disp_cmd_t e;
    e.command     = cmd;
    e.row         = r;
    e.col         = c;
    e.glyph       = g;
    e.clear_width = w;
    e.last        = 1'b0;
    step_cmds.push_back(e);
  endfunction

  // Row advance; a cursor at or past the last row pins there and scrolls.
  function automatic void line_down();
    int nrows;
    int ncols;
    nrows = (rows_q == 7'd0) ? 1 : int'(rows_q);
    ncols = (cols_q == 8'd0) ? 1 : int'(cols_q);
    if (int'(cur_row) + 1 >= nrows) begin
      cur_row = 7'(nrows - 1);
      add_cmd(CMD_SCROLL, '0, '0, '0, '0);
      add_cmd(CMD_CLEAR, cur_row, '0, '0, 8'(ncols));
      add_cmd(CMD_DRAW, cur_row, cur_col, '0, '0);
    end else begin
      cur_row = cur_row + 7'd1;
      add_cmd(CMD_MOVE, cur_row, cur_col, '0, '0);
    end
  endfunction

  function automatic void predict_commands(input logic [7:0] code);
    logic [6:0] ch;
    int         ncols;
    disp_cmd_t  e;
    ch    = code[6:0] & CharMask;
    ncols = (cols_q == 8'd0) ? 1 : int'(cols_q);
    step_cmds.delete();
    if (ch == CharNewline) begin
      line_down();
    end else if (ch == CharReturn) begin
      cur_col = 8'd0;
      add_cmd(CMD_MOVE, cur_row, cur_col, '0, '0);
    end else if (ch == CharBackspace) begin
      if (cur_col != 8'd0) begin
        cur_col = cur_col - 8'd1;
        add_cmd(CMD_MOVE, cur_row, cur_col, '0, '0);
      end
    end else if (ch >= CharSpace && ch != CharDel) begin
      add_cmd(CMD_GLYPH, cur_row, cur_col, ch, '0);
      add_cmd(CMD_DRAW, cur_row, cur_col, '0, '0);
      if (int'(cur_col) + 1 >= ncols) begin
        cur_col = 8'd0;
        line_down();
      end else begin
        cur_col = cur_col + 8'd1;
        add_cmd(CMD_MOVE, cur_row, cur_col, '0, '0);
      end
    end
    foreach (step_cmds[i]) begin
      e      = step_cmds[i];
      e.last = (i == step_cmds.size() - 1);
      pending_cmds.push_back(e);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic check_command();
    disp_cmd_t want;
    if (pending_cmds.size() == 0) begin
      report_mismatch($sformatf("command %0d with nothing expected", seen_cmd));
      return;
    end
    want = pending_cmds.pop_front();
    if (seen_cmd !== want.command)
      report_mismatch($sformatf("command got %0d want %0d", seen_cmd, want.command));
    if (seen_row !== want.row)
      report_mismatch($sformatf("row got %0d want %0d", seen_row, want.row));
    if (seen_col !== want.col)
      report_mismatch($sformatf("col got %0d want %0d", seen_col, want.col));
    if (seen_glyph !== want.glyph)
      report_mismatch($sformatf("glyph got %0h want %0h", seen_glyph, want.glyph));
    if (seen_width !== want.clear_width)
      report_mismatch($sformatf("clear_width got %0d want %0d", seen_width,
                                want.clear_width));
    if (seen_last !== want.last)
      report_mismatch($sformatf("last got %0b want %0b", seen_last, want.last));
  endtask

  // prediction before checking, so even a same-edge result finds its entry
  always @(posedge clk_i) begin
    if (in_fire) predict_commands(seen_char);
    if (out_fire) check_command();
  end

  always @(posedge clk_i) begin
    if (in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] code);
    while (in_idle_en && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= code;
    do @(posedge clk_i); while (!in_fire);
  endtask

  // drop valid, let all commands drain, then give a character with no
  // commands time to leave the pipeline
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgNumCols) cols_q = val;
    else rows_q = val[6:0];
    @(posedge clk_i);
  endtask

  task automatic set_screen(input logic [7:0] ncols, input logic [6:0] nrows);
    wait_idle();
    write_reg(CfgNumCols, ncols);
    write_reg(CfgNumRows, {1'b0, nrows});
  endtask

  function automatic logic [7:0] rand_char();
    int unsigned pick;
    logic [7:0]  c;
    pick = $urandom_range(99);
    if (pick < 62) c = 8'($urandom_range(8'h7E, 8'h20));
    else if (pick < 74) c = {1'b0, CharNewline};
    else if (pick < 82) c = {1'b0, CharBackspace};
    else if (pick < 87) c = {1'b0, CharReturn};
    else c = 8'($urandom_range(255));
    if ($urandom_range(9) == 0) c[7] = 1'b1;
    return c;
  endfunction

  // default 80x24 screen: printable extremes, high bit, controls, ignored codes
  task automatic test_basic_chars();
    logic [7:0] codes[$];
    codes = '{8'h08, 8'h41, 8'hC1, 8'h20, 8'h7E, 8'h7F, 8'hFF, 8'h00, 8'h1F,
              8'h88, 8'h8D, 8'h0A, 8'h8A};
    foreach (codes[i]) send_char(codes[i]);
  endtask

  // one-cell screen, then zero-sized registers that act as one
  task automatic test_minimal_screen();
    set_screen(8'd1, 7'd1);
    send_char("x");
    send_char({1'b0, CharNewline});
    send_char({1'b0, CharBackspace});
    set_screen(8'd0, 7'd0);
    send_char("y");
    send_char({1'b0, CharNewline});
  endtask

  // shrink the screen under the cursor
  task automatic test_cursor_off_screen();
    set_screen(8'd8, 7'd8);
    send_char("a");
    send_char("b");
    send_char("c");
    send_char("d");
    send_char({1'b0, CharNewline});
    send_char({1'b0, CharNewline});
    set_screen(8'd3, 7'd2);
    send_char({1'b0, CharBackspace});
    send_char("g");
    send_char({1'b0, CharNewline});
  endtask

  task automatic run_text(input int count);
    logic [7:0] c;
    logic [6:0] ch;
    int         used;
    used = 0;
    while (used < count) begin
      c  = rand_char();
      ch = c[6:0];
      send_char(c);
      if (!((ch < CharSpace && ch != CharNewline && ch != CharReturn &&
             ch != CharBackspace) || ch == CharDel))
        used++;
    end
  endtask

  task automatic test_random_text();
    set_screen(8'd255, 7'd127);
    run_text(25);
    set_screen(8'd4, 7'd3);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    run_text(35);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
    set_screen(8'd1, 7'd1);
    run_text(15);
    set_screen(8'd12, 7'd2);
    run_text(25);
    set_screen(8'($urandom_range(40, 1)), 7'($urandom_range(10, 1)));
    run_text(25);
    set_screen(8'($urandom_range(255)), 7'($urandom_range(127)));
    run_text(25);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_chars();
    test_minimal_screen();
    test_cursor_off_screen();
    test_random_text();
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/tcct_pkg.sv
design/tcct_decode.sv
design/text_console_cursor_tracker.sv
design/tcct_checker.sv
tb/tb.sv
